>>> hw/rtl/assert_macros.svh
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PNPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PNPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pnpl_pkg.sv
package pnpl_pkg;

  localparam int MAX_LIST     = 32;
  localparam int MAX_DIM      = 256;
  localparam int PHOTON_LIMIT = 131072;
  localparam int NUM_PIX      = MAX_DIM * MAX_DIM;
  localparam int PIX_W        = $clog2(NUM_PIX);
  localparam int DIST_W       = 35;
  localparam int ID_W         = 17;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] REG_LIST_LIMIT  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_CALC,
    B_WRITE
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [7:0]        row;
    logic [7:0]        col;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] sq_dist;
    logic [4:0]        slot;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] sq_dist;
  } entry_t;

endpackage

>>> hw/rtl/pnpl_in_if.sv
interface pnpl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  pixel_row;
  logic [7:0]  pixel_col;
  logic [16:0] photon_id;
  logic signed [16:0] photon_x;
  logic signed [16:0] photon_y;
  logic [4:0]  entry_slot;

  modport source (
    output valid, cmd, pixel_row, pixel_col, photon_id, photon_x, photon_y, entry_slot,
    input  ready
  );
  modport sink (
    input  valid, cmd, pixel_row, pixel_col, photon_id, photon_x, photon_y, entry_slot,
    output ready
  );
endinterface

>>> hw/rtl/pnpl_out_if.sv
interface pnpl_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  list_length;
  logic        kept;
  logic [16:0] read_id;
  logic        read_valid;

  modport source (
    output valid, list_length, kept, read_id, read_valid,
    input  ready
  );
  modport sink (
    input  valid, list_length, kept, read_id, read_valid,
    output ready
  );
endinterface

>>> hw/rtl/pnpl_queue.sv
module pnpl_queue import pnpl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

>>> hw/rtl/pnpl_front.sv
module pnpl_front import pnpl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pnpl_in_if.sink    in_ch,
  input  logic [8:0] grid_height_i,
  input  logic [8:0] grid_width_i,
  input  logic       init_done_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output item_t      q_item_o
);

  logic        s1_valid_q, s2_valid_q;
  item_t       s1_item_q, s2_item_q;
  logic [17:0] s1_adx_q, s1_ady_q;
  logic [35:0] s2_sqx_q, s2_sqy_q;
  logic        stall, accept;
  op_e         op;
  logic signed [17:0] hx, hy;
  logic signed [18:0] dx, dy;
  logic [18:0] adx, ady;
  logic [36:0] sum;
  item_t       in_item;

  assign stall       = s2_valid_q && q_full_i;
  assign in_ch.ready = init_done_i && !stall;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    case (in_ch.cmd)
      CMD_INSERT: op = (32'(in_ch.photon_id) < PHOTON_LIMIT) ? OP_INSERT : OP_NOP;
      CMD_CLEAR:  op = OP_CLEAR;
      CMD_READ:   op = OP_READ;
      default:    op = OP_NOP;
    endcase
  end

  // hit point relative to grid center, in 1/256 pixel
  assign hx  = $signed({2'b0, in_ch.pixel_row, 8'b0}) - $signed({2'b0, grid_height_i, 7'b0});
  assign hy  = $signed({2'b0, in_ch.pixel_col, 8'b0}) - $signed({2'b0, grid_width_i, 7'b0});
  assign dx  = 19'(in_ch.photon_x) - 19'(hx);
  assign dy  = 19'(in_ch.photon_y) - 19'(hy);
  assign adx = dx[18] ? 19'(-dx) : 19'(dx);
  assign ady = dy[18] ? 19'(-dy) : 19'(dy);

  always_comb begin
    in_item      = '0;
    in_item.op   = op;
    in_item.row  = in_ch.pixel_row;
    in_item.col  = in_ch.pixel_col;
    in_item.id   = in_ch.photon_id;
    in_item.slot = in_ch.entry_slot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (!stall) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s1_item_q <= in_item;
      s1_adx_q  <= adx[17:0];
      s1_ady_q  <= ady[17:0];
      s2_item_q <= s1_item_q;
      s2_sqx_q  <= s1_adx_q * s1_adx_q;
      s2_sqy_q  <= s1_ady_q * s1_ady_q;
    end
  end

  assign sum      = {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};
  assign q_push_o = s2_valid_q && !q_full_i;

  always_comb begin
    q_item_o         = s2_item_q;
    q_item_o.sq_dist = (sum[36:DIST_W] != '0) ? '1 : sum[DIST_W-1:0];
  end

endmodule

>>> hw/rtl/pnpl_back.sv
module pnpl_back import pnpl_pkg::*; #(
  parameter int MaxList = MAX_LIST
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  item_t      q_item_i,
  output logic       q_pop_o,
  input  logic [5:0] list_limit_i,
  output logic       init_done_o,
  pnpl_out_if.source out_ch
);

  localparam int LenW = $clog2(MaxList + 1);
  localparam int IdxW = (MaxList > 1) ? $clog2(MaxList) : 1;

  entry_t [MaxList-1:0] row_mem [NUM_PIX];
  logic   [LenW-1:0]    len_mem [NUM_PIX];

  back_state_e          state_q, state_d;
  logic [PIX_W-1:0]     clr_addr_q;
  item_t                cur_q;
  entry_t [MaxList-1:0] row_q, new_row;
  logic [LenW-1:0]      len_q, nlen, lim;
  logic [IdxW-1:0]      pos_q, pos;
  logic                 hit_q, hit;
  logic [MaxList-1:0]   mask;
  logic [PIX_W-1:0]     pix, len_waddr;
  logic [LenW-1:0]      len_wdata;
  logic                 len_we, row_we, kept, rvalid;
  logic [ID_W-1:0]      rid;
  entry_t               new_ent;
  logic                 out_valid_q;
  logic [5:0]           out_len_q;
  logic                 out_kept_q, out_rvalid_q;
  logic [ID_W-1:0]      out_rid_q;

  assign pix     = {cur_q.row, cur_q.col};
  assign lim     = ({1'b0, list_limit_i} > 7'(MaxList)) ? LenW'(MaxList) : LenW'(list_limit_i);
  assign new_ent = '{id: cur_q.id, sq_dist: cur_q.sq_dist};

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: if (clr_addr_q == PIX_W'(NUM_PIX - 1)) state_d = B_IDLE;
      B_IDLE:  if (q_valid_i && (!out_valid_q || out_ch.ready)) state_d = B_READ;
      B_READ:  state_d = B_CALC;
      B_CALC:  state_d = B_WRITE;
      B_WRITE: state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    init_done_o = 1'b1;
    q_pop_o     = 1'b0;
    len_we      = 1'b0;
    case (state_q)
      B_CLEAR: begin
        init_done_o = 1'b0;
        len_we      = 1'b1;
      end
      B_IDLE:  q_pop_o = q_valid_i && (!out_valid_q || out_ch.ready);
      B_WRITE: len_we  = 1'b1;
      default: ;
    endcase
  end

  // first stored entry at or beyond the new distance
  always_comb begin
    pos = '0;
    for (int k = 0; k < MaxList; k++) begin
      mask[k] = (7'(k) < 7'(len_q)) && (cur_q.sq_dist <= row_q[k].sq_dist);
    end
    for (int k = MaxList - 1; k >= 0; k--) begin
      if (mask[k]) pos = IdxW'(k);
    end
    hit = |mask;
  end

  always_comb begin
    new_row = row_q;
    nlen    = len_q;
    kept    = 1'b0;
    rvalid  = 1'b0;
    rid     = '0;
    row_we  = 1'b0;
    case (cur_q.op)
      OP_INSERT: begin
        if (hit_q) begin
          for (int k = 0; k < MaxList; k++) begin
            if (IdxW'(k) == pos_q) new_row[k] = new_ent;
            else if (IdxW'(k) > pos_q) new_row[k] = row_q[(k > 0) ? k - 1 : 0];
          end
          nlen   = (7'(len_q) + 7'd1 > 7'(lim)) ? len_q : len_q + LenW'(1);
          kept   = 1'b1;
          row_we = 1'b1;
        end else if (len_q < lim) begin
          for (int k = 0; k < MaxList; k++) begin
            if (7'(k) == 7'(len_q)) new_row[k] = new_ent;
          end
          nlen   = len_q + LenW'(1);
          kept   = 1'b1;
          row_we = 1'b1;
        end else if (len_q > lim) begin
          nlen = len_q - LenW'(1);
        end
      end
      OP_CLEAR: nlen = '0;
      OP_READ: begin
        rvalid = 7'(cur_q.slot) < 7'(len_q);
        for (int k = 0; k < MaxList; k++) begin
          if (rvalid && 7'(k) == 7'(cur_q.slot)) rid = row_q[k].id;
        end
      end
      default: ;
    endcase
  end

  assign len_waddr = (state_q == B_CLEAR) ? clr_addr_q : pix;
  assign len_wdata = (state_q == B_CLEAR) ? '0 : nlen;

  always_ff @(posedge clk_i) begin
    if (state_q == B_READ) begin
      row_q <= row_mem[pix];
      len_q <= len_mem[pix];
    end
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (state_q == B_WRITE && row_we) begin
      row_mem[pix] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_addr_q <= clr_addr_q + PIX_W'(1);
      end
      if (state_q == B_WRITE) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_item_i;
    end
    if (state_q == B_CALC) begin
      pos_q <= pos;
      hit_q <= hit;
    end
    if (state_q == B_WRITE) begin
      out_len_q    <= 6'(nlen);
      out_kept_q   <= kept;
      out_rid_q    <= rid;
      out_rvalid_q <= rvalid;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.list_length = out_len_q;
  assign out_ch.kept        = out_kept_q;
  assign out_ch.read_id     = out_rid_q;
  assign out_ch.read_valid  = out_rvalid_q;

endmodule

>>> hw/rtl/pixel_nearest_photon_list.sv
// Per-pixel nearest-photon lists, sorted by squared distance from the pixel hit point.
// Each transaction (insert, clear, read, no-op) gives one result transaction. The front
// end classifies the command and computes the distance in a two-stage pipeline, then a
// two-entry queue feeds the back end, which does one read-modify-write of the pixel's
// whole list row per transaction (the idle state that pops the queue, read, compare,
// write); the result register frees in the cycle its result is taken, and the next
// transaction is popped only after the last row write, so a steady stream is limited
// by that row update. After reset the list-length memory is cleared one pixel per
// cycle, during which no input transaction is accepted; configuration writes are
// taken at any time.
`include "assert_macros.svh"

module pixel_nearest_photon_list import pnpl_pkg::*; #(
  parameter int MaxList = MAX_LIST
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pnpl_in_if.sink    in_ch,
  pnpl_out_if.source out_ch,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  logic [5:0] list_limit_q;
  logic [8:0] grid_height_q, grid_width_q;
  logic       init_done, q_push, q_full, q_pop, q_valid;
  item_t      q_in_item, q_out_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_limit_q  <= 6'd20;
      grid_height_q <= 9'd224;
      grid_width_q  <= 9'd224;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LIST_LIMIT:  list_limit_q  <= cfg_data_i[5:0];
        REG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pnpl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .grid_height_i (grid_height_q),
    .grid_width_i  (grid_width_q),
    .init_done_i   (init_done),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in_item)
  );

  pnpl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out_item)
  );

  pnpl_back #(
    .MaxList (MaxList)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_out_item),
    .q_pop_o      (q_pop),
    .list_limit_i (list_limit_q),
    .init_done_o  (init_done),
    .out_ch       (out_ch)
  );

  `PNPL_ASSERT_NOW(a_no_accept_in_clear, clk_i, rst_ni, !init_done, !in_ch.ready, "input accepted during clearing pass")
  `PNPL_ASSERT_NEXT(a_init_stays_done, clk_i, rst_ni, init_done, init_done, "clearing pass restarted")
  `PNPL_ASSERT_NOW(a_len_bound, clk_i, rst_ni, out_ch.valid, 7'(out_ch.list_length) <= 7'(MaxList), "list length beyond storage")
  `PNPL_ASSERT_NOW(a_kept_xor_read, clk_i, rst_ni, out_ch.valid, !(out_ch.kept && out_ch.read_valid), "insert and read flags both set")

endmodule

>>> tb/sv/pnpl_list_checker.sv
module pnpl_list_checker import pnpl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pnpl_in_if         in_ch,
  pnpl_out_if        out_ch,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct {
    logic [5:0]      len;
    logic            kept;
    logic [ID_W-1:0] rid;
    logic            rvalid;
  } list_result_t;

  logic [5:0] limit_q;
  logic [8:0] height_q;
  logic [8:0] width_q;

  logic [5:0]        lengths [NUM_PIX];
  logic [ID_W-1:0]   slot_ids [int];
  logic [DIST_W-1:0] slot_dists [int];

  list_result_t result_q[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  initial begin
    fails = 0;
    foreach (lengths[i]) lengths[i] = '0;
  end

  task automatic update_list(input logic [1:0] cmd, input logic [7:0] row,
                             input logic [7:0] col, input logic [ID_W-1:0] id,
                             input logic signed [16:0] px, input logic signed [16:0] py,
                             input logic [4:0] slot, output list_result_t res);
    int pix;
    int base;
    int len;
    int lim;
    int pos;
    int top;
    longint dx;
    longint dy;
    longint d;
    pix = {row, col};
    base = pix * MAX_LIST;
    len = lengths[pix];
    lim = (limit_q > MAX_LIST) ? MAX_LIST : limit_q;
    res.kept = 1'b0;
    res.rid = '0;
    res.rvalid = 1'b0;
    if (op_e'(cmd) == OP_INSERT && id < PHOTON_LIMIT) begin
      dx = longint'(px) - (longint'(row) * 256 - longint'(height_q) * 128);
      dy = longint'(py) - (longint'(col) * 256 - longint'(width_q) * 128);
      d = dx * dx + dy * dy;
      if (d > (64'd1 << DIST_W) - 1) d = (64'd1 << DIST_W) - 1;
      pos = len;
      for (int k = len - 1; k >= 0; k--) begin
        if (d <= slot_dists[base + k]) pos = k;
      end
      if (pos < len) begin
        top = (len < MAX_LIST) ? len : MAX_LIST - 1;
        for (int k = top; k > pos; k--) begin
          slot_ids[base + k] = slot_ids[base + k - 1];
          slot_dists[base + k] = slot_dists[base + k - 1];
        end
        slot_ids[base + pos] = id;
        slot_dists[base + pos] = d[DIST_W-1:0];
        len++;
        if (len > lim) len--;
        res.kept = 1'b1;
      end else if (len < lim) begin
        slot_ids[base + len] = id;
        slot_dists[base + len] = d[DIST_W-1:0];
        len++;
        res.kept = 1'b1;
      end else if (len > lim) begin
        len--;
      end
      lengths[pix] = len[5:0];
    end else if (op_e'(cmd) == OP_CLEAR) begin
      len = 0;
      lengths[pix] = '0;
    end else if (op_e'(cmd) == OP_READ) begin
      if (slot < len) begin
        res.rid = slot_ids[base + slot];
        res.rvalid = 1'b1;
      end
    end
    res.len = len[5:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t res;
    list_result_t want;
    if (!rst_ni) begin
      limit_q  <= 6'd20;
      height_q <= 9'd224;
      width_q  <= 9'd224;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LIST_LIMIT:  limit_q <= cfg_data_i[5:0];
          REG_GRID_HEIGHT: height_q <= cfg_data_i;
          REG_GRID_WIDTH:  width_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        update_list(in_ch.cmd, in_ch.pixel_row, in_ch.pixel_col, in_ch.photon_id,
                    in_ch.photon_x, in_ch.photon_y, in_ch.entry_slot, res);
        result_q = {result_q, res};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transaction");
          fails++;
        end else begin
          want = result_q.pop_front();
          if (out_ch.list_length !== want.len) begin
            $error("list_length: expected %0d, got %0d", want.len, out_ch.list_length);
            fails++;
          end
          if (out_ch.kept !== want.kept) begin
            $error("kept: expected %0d, got %0d", want.kept, out_ch.kept);
            fails++;
          end
          if (out_ch.read_id !== want.rid) begin
            $error("read_id: expected %0d, got %0d", want.rid, out_ch.read_id);
            fails++;
          end
          if (out_ch.read_valid !== want.rvalid) begin
            $error("read_valid: expected %0d, got %0d", want.rvalid, out_ch.read_valid);
            fails++;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/tb_pixel_nearest_photon_list.sv
module tb_pixel_nearest_photon_list;
  import pnpl_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [8:0] cfg_data_i;
  int         fail_count;
  int         pending;
  int         idle_cycles;
  bit         calm;
  logic [7:0] pool_row [8];
  logic [7:0] pool_col [8];
  logic [8:0] cur_height;
  logic [8:0] cur_width;

  pnpl_in_if  in_ch();
  pnpl_out_if out_ch();

  pixel_nearest_photon_list uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  pnpl_list_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || pending == 0 && !in_ch.valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
    end
  end

  task automatic send(input op_e op, input logic [7:0] row, input logic [7:0] col,
                      input logic [16:0] id, input logic [16:0] px, input logic [16:0] py,
                      input logic [4:0] slot);
    if (!calm && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid      = 1'b1;
    in_ch.cmd        = op;
    in_ch.pixel_row  = row;
    in_ch.pixel_col  = col;
    in_ch.photon_id  = id;
    in_ch.photon_x   = px;
    in_ch.photon_y   = py;
    in_ch.entry_slot = slot;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_item();
    int sel;
    int p;
    logic [7:0] row;
    logic [7:0] col;
    logic [16:0] px;
    logic [16:0] py;
    op_e op;
    p = $urandom_range(0, 7);
    row = pool_row[p];
    col = pool_col[p];
    if ($urandom_range(0, 9) == 0) begin
      row = 8'($urandom);
      col = 8'($urandom);
    end
    sel = $urandom_range(0, 99);
    if (sel < 62) op = OP_INSERT;
    else if (sel < 90) op = OP_READ;
    else if (sel < 95) op = OP_CLEAR;
    else op = OP_NOP;
    if ($urandom_range(0, 1) == 0) begin
      px = 17'($urandom);
      py = 17'($urandom);
    end else begin
      px = 17'(int'(row) * 256 - int'(cur_height) * 128 + $urandom_range(0, 64) - 32);
      py = 17'(int'(col) * 256 - int'(cur_width) * 128 + $urandom_range(0, 64) - 32);
    end
    send(op, row, col, 17'($urandom), px, py, 5'($urandom));
  endtask

  task automatic run_phase(input int n, input logic [8:0] lim, input logic [8:0] gh,
                           input logic [8:0] gw);
    drain();
    write_reg(REG_LIST_LIMIT, lim);
    write_reg(REG_GRID_HEIGHT, gh);
    write_reg(REG_GRID_WIDTH, gw);
    cur_height = gh;
    cur_width = gw;
    for (int i = 0; i < n; i++) begin
      calm = (i % 100) >= 80;
      random_item();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    calm = 1'b0;
    idle_cycles = 0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_LIST_LIMIT;
    cfg_data_i = '0;
    cur_height = 9'd224;
    cur_width = 9'd224;
    in_ch.valid = 1'b0;
    in_ch.cmd = OP_NOP;
    in_ch.pixel_row = '0;
    in_ch.pixel_col = '0;
    in_ch.photon_id = '0;
    in_ch.photon_x = '0;
    in_ch.photon_y = '0;
    in_ch.entry_slot = '0;
    pool_row[0] = 8'd0;   pool_col[0] = 8'd0;
    pool_row[1] = 8'd255; pool_col[1] = 8'd255;
    pool_row[2] = 8'd0;   pool_col[2] = 8'd255;
    for (int i = 3; i < 8; i++) begin
      pool_row[i] = 8'($urandom);
      pool_col[i] = 8'($urandom);
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    send(OP_READ, 8'd0, 8'd0, 17'd0, 17'd0, 17'd0, 5'd0);
    send(OP_INSERT, 8'd0, 8'd0, 17'd0, 17'h10000, 17'h10000, 5'd0);
    send(OP_INSERT, 8'd0, 8'd0, 17'h1FFFF, 17'h0FFFF, 17'h0FFFF, 5'd31);
    send(OP_INSERT, 8'd0, 8'd0, 17'd5, 17'h10000, 17'h10000, 5'd0);
    send(OP_INSERT, 8'd0, 8'd0, 17'd6, 17'h0FFFF, 17'h10000, 5'd0);
    send(OP_READ, 8'd0, 8'd0, 17'd0, 17'd0, 17'd0, 5'd0);
    send(OP_READ, 8'd0, 8'd0, 17'd0, 17'd0, 17'd0, 5'd1);
    send(OP_READ, 8'd0, 8'd0, 17'd0, 17'd0, 17'd0, 5'd3);
    send(OP_READ, 8'd0, 8'd0, 17'd0, 17'd0, 17'd0, 5'd31);
    send(OP_NOP, 8'd0, 8'd0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 5'd31);
    send(OP_INSERT, 8'd255, 8'd255, 17'd77, 17'h0FFFF, 17'h10000, 5'd0);
    send(OP_INSERT, 8'd255, 8'd255, 17'd78, 17'h0, 17'h0, 5'd0);
    send(OP_READ, 8'd255, 8'd255, 17'd0, 17'd0, 17'd0, 5'd1);
    send(OP_CLEAR, 8'd0, 8'd0, 17'd0, 17'd0, 17'd0, 5'd0);
    send(OP_READ, 8'd0, 8'd0, 17'd0, 17'd0, 17'd0, 5'd0);
    send(OP_INSERT, 8'd0, 8'd0, 17'd9, 17'd0, 17'd0, 5'd0);

    run_phase(290, 9'd32, 9'd256, 9'd256);
    run_phase(290, 9'd3, 9'd1, 9'd1);
    run_phase(290, 9'd63, 9'd511, 9'd511);
    run_phase(290, 9'd0, 9'd0, 9'd0);
    run_phase(290, 9'd1, 9'd100, 9'd37);
    drain();
    write_reg(REG_LIST_LIMIT, 9'd20);
    write_reg(REG_GRID_HEIGHT, 9'd224);
    write_reg(REG_GRID_WIDTH, 9'd224);
    cur_height = 9'd224;
    cur_width = 9'd224;
    for (int i = 0; i < 200; i++) begin
      calm = (i % 100) >= 60;
      random_item();
    end
    calm = 1'b1;
    for (int i = 0; i < 100; i++) random_item();
    drain();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
